>>> rtl/spc_pkg.sv
// Shared types and constants for the stack permutation checker.
package spc_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int VALUE_W   = 16;
    localparam int COUNT_W   = 11;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_TARGET = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [VALUE_W-1:0] value;
        logic               last;
    } in_t;

    typedef struct packed {
        logic               is_stack_perm;
        logic [COUNT_W-1:0] source_count;
    } out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // take the presented input transfer
        logic rd_src;    // read the source FIFO
        logic rd_next;   // read at head + 1 instead of head
        logic rd_stk;    // read the stack top
        logic pop;       // drop the stack top
        logic consume;   // retire the source value just read
        logic set_fail;  // source exhausted without a match
        logic verdict;   // emit the result and clear the run
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_target;
        logic in_last;
        logic last;
        logic fail;
        logic stk_nonempty;
        logic src_avail;
        logic src_more;
        logic top_match;
        logic src_match;
        logic out_free;
    } status_t;

endpackage

>>> rtl/spc_datapath.sv
// Datapath: source FIFO, stack memory, pointers, fail flag and result register.
module spc_datapath #(
    parameter int DEPTH = spc_pkg::DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  spc_pkg::in_t     s_payload,
    input  spc_pkg::cmd_t    cmd,
    output spc_pkg::status_t st,
    output logic             m_valid,
    input  logic             m_ready,
    output spc_pkg::out_t    m_payload
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int EXT_W = CW + spc_pkg::COUNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [spc_pkg::VALUE_W-1:0] source_mem [DEPTH];
    logic [spc_pkg::VALUE_W-1:0] stack_mem  [DEPTH];

    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic          fail_reg, fail_next;
    logic [spc_pkg::VALUE_W-1:0] target_reg;
    logic          last_reg;
    logic [spc_pkg::VALUE_W-1:0] src_rdata_reg;
    logic [spc_pkg::VALUE_W-1:0] stk_rdata_reg;
    logic          m_valid_reg;
    spc_pkg::out_t m_data_reg;

    logic [CW-1:0]    head_inc;
    logic [CW-1:0]    depth_dec;
    logic [CW-1:0]    src_addr;
    logic             load_wr;
    logic             push;
    logic [EXT_W-1:0] count_ext;

    assign head_inc  = head_reg + CW'(1);
    assign depth_dec = depth_reg - CW'(1);
    assign src_addr  = cmd.rd_next ? head_inc : head_reg;
    assign load_wr   = cmd.accept && (s_payload.req_type == spc_pkg::REQ_LOAD)
                       && (tail_reg < DEPTH_C);
    assign push      = cmd.consume && !st.src_match && (depth_reg < DEPTH_C);
    assign count_ext = EXT_W'(tail_reg);

    // Status back to the controller
    assign st.in_target    = (s_payload.req_type == spc_pkg::REQ_TARGET);
    assign st.in_last      = s_payload.last;
    assign st.last         = last_reg;
    assign st.fail         = fail_reg;
    assign st.stk_nonempty = (depth_reg != '0);
    assign st.src_avail    = (head_reg < tail_reg);
    assign st.src_more     = (head_inc < tail_reg);
    assign st.top_match    = (stk_rdata_reg == target_reg);
    assign st.src_match    = (src_rdata_reg == target_reg);
    assign st.out_free     = !m_valid_reg || m_ready;

    // Next pointer and flag values
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        depth_next = depth_reg;
        fail_next  = fail_reg;
        if (cmd.verdict) begin
            head_next  = '0;
            tail_next  = '0;
            depth_next = '0;
            fail_next  = 1'b0;
        end else begin
            if (load_wr) begin
                tail_next = tail_reg + CW'(1);
            end
            if (cmd.consume) begin
                head_next = head_inc;
            end
            if (cmd.pop) begin
                depth_next = depth_dec;
            end else if (push) begin
                depth_next = depth_reg + CW'(1);
            end
            if (cmd.set_fail) begin
                fail_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            depth_reg   <= '0;
            fail_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            depth_reg <= depth_next;
            fail_reg  <= fail_next;
            if (cmd.verdict) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            target_reg <= s_payload.value;
            last_reg   <= s_payload.last;
        end
        if (cmd.verdict) begin
            m_data_reg.is_stack_perm <= !fail_reg && (depth_reg == '0)
                                        && (head_reg == tail_reg);
            m_data_reg.source_count  <= count_ext[spc_pkg::COUNT_W-1:0];
        end
    end

    // Source FIFO memory
    always_ff @(posedge aclk) begin
        if (load_wr) begin
            source_mem[tail_reg[AW-1:0]] <= s_payload.value;
        end
        if (cmd.rd_src) begin
            src_rdata_reg <= source_mem[src_addr[AW-1:0]];
        end
    end

    // Stack memory
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_mem[depth_reg[AW-1:0]] <= src_rdata_reg;
        end
        if (cmd.rd_stk) begin
            stk_rdata_reg <= stack_mem[depth_dec[AW-1:0]];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

endmodule

>>> rtl/spc_ctrl.sv
// Controller: sequences loads, target matching and the verdict.
module spc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  spc_pkg::status_t st,
    output spc_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TOP  = 2'd1;
    localparam logic [1:0] ST_SRC  = 2'd2;
    localparam logic [1:0] ST_VERD = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] done_state;
    logic [1:0] done_state_in;

    // Where a finished target goes: verdict if it was the last one
    assign done_state    = st.last ? ST_VERD : ST_IDLE;
    assign done_state_in = st.in_last ? ST_VERD : ST_IDLE;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (st.in_target) begin
                        if (st.fail) begin
                            state_next = done_state_in;
                        end else if (st.stk_nonempty) begin
                            cmd.rd_stk = 1'b1;
                            state_next = ST_TOP;
                        end else if (st.src_avail) begin
                            cmd.rd_src = 1'b1;
                            state_next = ST_SRC;
                        end else begin
                            cmd.set_fail = 1'b1;
                            state_next   = done_state_in;
                        end
                    end
                end
            end
            ST_TOP: begin
                if (st.top_match) begin
                    cmd.pop    = 1'b1;
                    state_next = done_state;
                end else if (st.src_avail) begin
                    cmd.rd_src = 1'b1;
                    state_next = ST_SRC;
                end else begin
                    cmd.set_fail = 1'b1;
                    state_next   = done_state;
                end
            end
            ST_SRC: begin
                // Retire the value read; push it unless it matches
                cmd.consume = 1'b1;
                if (st.src_match) begin
                    state_next = done_state;
                end else if (st.src_more) begin
                    cmd.rd_src  = 1'b1;
                    cmd.rd_next = 1'b1;
                end else begin
                    cmd.set_fail = 1'b1;
                    state_next   = done_state;
                end
            end
            ST_VERD: begin
                // Hold until the result register is free
                if (st.out_free) begin
                    cmd.verdict = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/stack_permutation_checker_core.sv
// Top level of the stack permutation checker.
// Load transfers (req_type 0) fill a source FIFO of DEPTH entries and are taken whenever
// the controller is idle; loads beyond DEPTH are dropped. A target transfer (req_type 1)
// is accepted, then checked against the stack top when the stack holds anything, and
// then source values move from the FIFO onto the stack until a value matches or the
// FIFO runs dry. The target marked last then has the verdict written, and stalls the
// input for as long as the previous result still waits in the output register. Each
// scanned value is fed to the compare by a registered memory read. Further loads are
// taken while a result waits; the verdict clears the run for the next.
module stack_permutation_checker_core #(
    parameter int DEPTH = spc_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  spc_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output spc_pkg::out_t m_payload
);

    spc_pkg::cmd_t    cmd;
    spc_pkg::status_t st;

    spc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    spc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

>>> sim/stack_permutation_checker_core_tb.sv
// Self-checking testbench for the stack permutation checker core.
`timescale 1ns / 1ps

module stack_permutation_checker_core_tb;

    localparam int SRC_CAP = spc_pkg::DEPTH_DEF;
    localparam int VALUE_W = spc_pkg::VALUE_W;
    localparam int COUNT_W = spc_pkg::COUNT_W;

    // Verdict scoreboard: mirrors the source FIFO and the stack, queues expected verdicts
    class perm_verdict_sb;
        logic [VALUE_W-1:0] src_mem [SRC_CAP];
        logic [VALUE_W-1:0] stk_mem [SRC_CAP];
        int unsigned        src_head;
        int unsigned        src_tail;
        int unsigned        stk_depth;
        bit                 failed;
        spc_pkg::out_t      verdict_q[$];
        int                 errors;

        function new();
            src_head  = 0;
            src_tail  = 0;
            stk_depth = 0;
            failed    = 1'b0;
            errors    = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // Match one target against the stack top, then scan the source onto the stack
        function void match_target(logic [VALUE_W-1:0] target);
            logic [VALUE_W-1:0] v;
            if (failed)
                return;
            if (stk_depth > 0 && stk_mem[stk_depth-1] == target) begin
                stk_depth--;
                return;
            end
            while (src_head < src_tail) begin
                v = src_mem[src_head];
                src_head++;
                if (v == target)
                    return;
                if (stk_depth < SRC_CAP) begin
                    stk_mem[stk_depth] = v;
                    stk_depth++;
                end
            end
            failed = 1'b1;
        endfunction

        // Note an accepted input transfer and queue the verdict it causes, if any
        function void take_transfer(spc_pkg::in_t it);
            spc_pkg::out_t exp_v;
            if (it.req_type == spc_pkg::REQ_LOAD) begin
                if (src_tail < SRC_CAP) begin
                    src_mem[src_tail] = it.value;
                    src_tail++;
                end
                return;
            end
            match_target(it.value);
            if (!it.last)
                return;
            exp_v.is_stack_perm = !failed && stk_depth == 0 && src_head == src_tail;
            exp_v.source_count  = src_tail[COUNT_W-1:0];
            verdict_q.push_back(exp_v);
            src_head  = 0;
            src_tail  = 0;
            stk_depth = 0;
            failed    = 1'b0;
        endfunction

        // Compare an accepted result with the oldest expected verdict
        task check_verdict(spc_pkg::out_t got);
            spc_pkg::out_t exp_v;
            if (verdict_q.size() == 0) begin
                report($sformatf("unexpected result perm=%0b count=%0d",
                                 got.is_stack_perm, got.source_count));
                return;
            end
            exp_v = verdict_q.pop_front();
            if (got.is_stack_perm !== exp_v.is_stack_perm)
                report($sformatf("is_stack_perm got %0b exp %0b (count %0d)",
                                 got.is_stack_perm, exp_v.is_stack_perm, exp_v.source_count));
            if (got.source_count !== exp_v.source_count)
                report($sformatf("source_count got %0d exp %0d",
                                 got.source_count, exp_v.source_count));
        endtask

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    spc_pkg::in_t  s_payload = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    spc_pkg::out_t m_payload;

    perm_verdict_sb sb;
    spc_pkg::in_t   run_q[$];
    int             idle_pct  = 0;
    int             stall_pct = 0;
    int             hold_left = 0;
    int             sent      = 0;

    stack_permutation_checker_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function void add_item(logic req, logic [VALUE_W-1:0] val, logic lst);
        spc_pkg::in_t it;
        it.req_type = req;
        it.value    = val;
        it.last     = lst;
        run_q.push_back(it);
    endfunction

    // Offer each queued transfer, idling between them at the current rate
    task send_run();
        spc_pkg::in_t it;
        while (run_q.size() > 0) begin
            it = run_q.pop_front();
            if ($urandom_range(99) < idle_pct) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while ($urandom_range(99) < idle_pct);
            end
            s_valid   <= 1'b1;
            s_payload <= it;
            do @(posedge aclk); while (!s_ready);
            sb.take_transfer(it);
            sent++;
        end
    endtask

    // Build one run: loads, a stack walk over them as targets, optionally broken or shuffled
    task gen_run();
        logic [VALUE_W-1:0] src[$];
        logic [VALUE_W-1:0] tgt[$];
        logic [VALUE_W-1:0] stk[$];
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] t;
        int n, kind, i, j, k, li, ti;
        n    = ($urandom_range(19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        kind = $urandom_range(99);
        base = VALUE_W'($urandom());
        for (i = 0; i < n; i++)
            src.push_back(kind < 15 ? VALUE_W'($urandom_range(3)) : VALUE_W'(base + i));
        // walk the stack at random to get a reachable order
        i = 0;
        while (i < n || stk.size() > 0) begin
            if (i < n && (stk.size() == 0 || $urandom_range(1))) begin
                stk.push_back(src[i]);
                i++;
            end else begin
                tgt.push_back(stk.pop_back());
            end
        end
        // break a share of the runs
        if (kind >= 60 && kind < 85) begin
            case ($urandom_range(3))
                0: if (tgt.size() > 1) begin
                    j = $urandom_range(tgt.size() - 1);
                    k = $urandom_range(tgt.size() - 1);
                    t = tgt[j];
                    tgt[j] = tgt[k];
                    tgt[k] = t;
                end
                1: if (tgt.size() > 0) tgt[$urandom_range(tgt.size() - 1)] = VALUE_W'($urandom());
                2: if (tgt.size() > 1) void'(tgt.pop_back());
                default: tgt.push_back(VALUE_W'($urandom()));
            endcase
        end
        if (tgt.size() == 0)
            tgt.push_back(VALUE_W'($urandom()));
        // merge loads and targets; noisy runs interleave them and set last on loads
        li = 0;
        ti = 0;
        while (li < n || ti < tgt.size()) begin
            if (li < n && (kind < 85 || ti == tgt.size() - 1 || $urandom_range(1))) begin
                add_item(spc_pkg::REQ_LOAD, src[li],
                         kind >= 85 ? 1'($urandom_range(1)) : 1'b0);
                li++;
            end else begin
                add_item(spc_pkg::REQ_TARGET, tgt[ti], ti == tgt.size() - 1);
                ti++;
            end
        end
    endtask

    // Result side: check accepted results, stall at random or hold off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_verdict(m_payload);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        int i;
        bit pressed;
        sb      = new();
        pressed = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extreme values, direct match, then pop
        add_item(spc_pkg::REQ_LOAD,   16'h0000, 1'b0);
        add_item(spc_pkg::REQ_LOAD,   16'hFFFF, 1'b0);
        add_item(spc_pkg::REQ_TARGET, 16'hFFFF, 1'b0);
        add_item(spc_pkg::REQ_TARGET, 16'h0000, 1'b1);
        // last set on a load is ignored
        add_item(spc_pkg::REQ_LOAD,   16'h0005, 1'b1);
        add_item(spc_pkg::REQ_TARGET, 16'h0005, 1'b1);
        // target with an empty source
        add_item(spc_pkg::REQ_TARGET, 16'h0007, 1'b1);
        // targets after a failure, and a load after targets
        add_item(spc_pkg::REQ_LOAD,   16'h0001, 1'b0);
        add_item(spc_pkg::REQ_LOAD,   16'h0002, 1'b0);
        add_item(spc_pkg::REQ_TARGET, 16'h0003, 1'b0);
        add_item(spc_pkg::REQ_TARGET, 16'h0002, 1'b0);
        add_item(spc_pkg::REQ_LOAD,   16'h0009, 1'b0);
        add_item(spc_pkg::REQ_TARGET, 16'h0002, 1'b1);
        // load after a target, still a permutation
        add_item(spc_pkg::REQ_LOAD,   16'h0001, 1'b0);
        add_item(spc_pkg::REQ_TARGET, 16'h0001, 1'b0);
        add_item(spc_pkg::REQ_LOAD,   16'h0002, 1'b0);
        add_item(spc_pkg::REQ_TARGET, 16'h0002, 1'b1);
        // source left over
        add_item(spc_pkg::REQ_LOAD,   16'h0001, 1'b0);
        add_item(spc_pkg::REQ_LOAD,   16'h0002, 1'b0);
        add_item(spc_pkg::REQ_TARGET, 16'h0001, 1'b1);
        // stack left over
        add_item(spc_pkg::REQ_LOAD,   16'h0001, 1'b0);
        add_item(spc_pkg::REQ_LOAD,   16'h0002, 1'b0);
        add_item(spc_pkg::REQ_TARGET, 16'h0002, 1'b1);
        send_run();

        // overfill the source, then scan all of it onto the stack
        for (i = 0; i < SRC_CAP + 6; i++)
            add_item(spc_pkg::REQ_LOAD, VALUE_W'(i), 1'b0);
        add_item(spc_pkg::REQ_TARGET, VALUE_W'(SRC_CAP - 1), 1'b1);
        send_run();

        // random runs across the idling phases
        sent = 0;
        while (sent < 800) begin
            if (sent < 200) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else if (sent < 400) begin
                idle_pct  = 71;
                stall_pct = 0;
            end else if (sent < 600) begin
                idle_pct  = 0;
                stall_pct = 71;
            end else begin
                idle_pct  = 27;
                stall_pct = 27;
            end
            // long hold-off on the result side so that the block backs up
            if (!pressed && sent >= 100) begin
                hold_left = 400;
                pressed   = 1'b1;
            end
            gen_run();
            send_run();
        end
        s_valid   <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;

        // drain outstanding verdicts, then watch for stray results
        while (sb.pending() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/spc_pkg.sv
rtl/spc_datapath.sv
rtl/spc_ctrl.sv
rtl/stack_permutation_checker_core.sv
sim/stack_permutation_checker_core_tb.sv
